@@ src/arpc_pkg.sv @@
`default_nettype none
package arpc_pkg;

  localparam int ENTRIES   = 8;
  localparam int AGE_LIMIT = 65536;
  localparam int AGE_MAXI  = 2 * AGE_LIMIT - 1;
  localparam int AGE_W     = $clog2(2 * AGE_LIMIT);
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int IP_W      = 32;
  localparam int MAC_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [AGE_W-1:0] AGE_LIM_V = AGE_W'(AGE_LIMIT);
  localparam logic [AGE_W-1:0] AGE_MAX_V = AGE_W'(AGE_MAXI);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ADD    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTER_IP   = 2'd2;

  typedef enum logic [1:0] {
    WALK_LOOKUP,
    WALK_ADD,
    WALK_UPDATE
  } walk_mode_t;

  // Walk record that travels down the row of cells, one cell per cycle.
  typedef struct packed {
    logic             act;
    walk_mode_t       mode;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [AGE_W-1:0] runmax;
    logic             hit;
    logic [MAC_W-1:0] hit_mac;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [AGE_W-1:0] oldest;
    logic [IDX_W-1:0] old_idx;
  } walk_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } fill_t;

endpackage
`default_nettype wire

@@ src/arpc_cell.sv @@
`default_nettype none
module arpc_cell
  import arpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] cell_id,
  input  wire walk_t            rec_in,
  input  wire fill_t            fill,
  output walk_t                 rec_out
);

  logic             valid_r, valid_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic [IP_W-1:0]  ip_r, ip_nxt;
  logic [MAC_W-1:0] mac_r, mac_nxt;
  walk_t            rec_r, rec_nxt;
  logic             match;

  always_comb begin
    valid_nxt = valid_r;
    age_nxt   = age_r;
    ip_nxt    = ip_r;
    mac_nxt   = mac_r;
    rec_nxt   = rec_in;
    match     = valid_r && (ip_r == rec_in.ip);
    if (rec_in.act && !rec_in.hit) begin
      case (rec_in.mode)
        WALK_UPDATE: begin
          if (match) begin
            mac_nxt     = rec_in.mac;
            age_nxt     = '0;
            rec_nxt.hit = 1'b1;
          end
        end
        WALK_LOOKUP, WALK_ADD: begin
          if (match) begin
            age_nxt         = '0;
            rec_nxt.hit     = 1'b1;
            rec_nxt.hit_mac = mac_r;
            if (rec_in.mode == WALK_ADD) begin
              mac_nxt = rec_in.mac;
            end
          end else if (valid_r) begin
            age_nxt = (age_r >= AGE_MAX_V) ? AGE_MAX_V : age_r + AGE_W'(1);
            if (age_r > rec_in.runmax) begin
              rec_nxt.runmax = age_r;
              if (age_r >= AGE_LIM_V) begin
                valid_nxt = 1'b0;
              end
            end
          end
          // Replacement choice is made on the state as this cell leaves it.
          if (!match && !rec_in.free_found) begin
            if (!valid_nxt) begin
              rec_nxt.free_found = 1'b1;
              rec_nxt.free_idx   = cell_id;
            end else if (age_nxt > rec_in.oldest) begin
              rec_nxt.oldest  = age_nxt;
              rec_nxt.old_idx = cell_id;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (fill.en && (fill.idx == cell_id)) begin
      valid_nxt = 1'b1;
      age_nxt   = '0;
      ip_nxt    = fill.ip;
      mac_nxt   = fill.mac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      rec_r.act   <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      rec_r       <= rec_nxt;
    end
    age_r <= age_nxt;
    ip_r  <= ip_nxt;
    mac_r <= mac_nxt;
  end

  assign rec_out = rec_r;

endmodule
`default_nettype wire

@@ src/arp_cache_lookup_and_learn_unit.sv @@
// ARP cache with lookup and learn, eight entries held in a row of cells.
// Input channel: in_valid/in_stall carry an opcode (lookup or add), an IPv4
// address and, for an add, a MAC address. Each transfer gives exactly one
// result on out_valid/out_stall: hit, mac_out and send_request.
// Configuration (own address, netmask, router address) is written through
// cfg_we/cfg_index/cfg_wdata; the user writes it only while the block is idle, the block does not enforce this.
// Items answered without a walk (router shortcut, add for own or router
// address) put their result in the pending register, from which it moves
// to the output register. All other items send a record from the launch
// register through the cells, one cell per cycle, and then through the
// pending and output registers. One item is in work at a time: the next
// transfer is taken only once the last result has left the pending
// register for the output register.
// A finished result waits in the output register while out_stall is high;
// a new item may be taken meanwhile, but its own result waits until the
// output register has been emptied.
// Reset (synchronous, active low) empties the cache, forgets the router
// MAC and restores the configuration registers to their defaults.
`default_nettype none
module arp_cache_lookup_and_learn_unit
  import arpc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_opcode,
  input  wire logic [IP_W-1:0]      in_ip_addr,
  input  wire logic [MAC_W-1:0]     in_mac_in,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_hit,
  output logic [MAC_W-1:0]          out_mac_out,
  output logic                      out_send_request,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic [IP_W-1:0]  own_ip_r, own_ip_nxt;
  logic [IP_W-1:0]  mask_r, mask_nxt;
  logic [IP_W-1:0]  router_ip_r, router_ip_nxt;
  logic [MAC_W-1:0] router_mac_r, router_mac_nxt;
  logic             busy_r, busy_nxt;
  walk_t            launch_r, launch_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic             pend_hit_r, pend_hit_nxt;
  logic [MAC_W-1:0] pend_mac_r, pend_mac_nxt;
  logic             pend_req_r, pend_req_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic [MAC_W-1:0] out_mac_r, out_mac_nxt;
  logic             out_req_r, out_req_nxt;

  walk_t chain [0:ENTRIES];
  walk_t exit_rec;
  fill_t fill_w;
  logic  accept;
  logic  shortcut;
  logic  out_free;

  assign chain[0] = launch_r;
  assign exit_rec = chain[ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arpc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_id (IDX_W'(g)),
      .rec_in  (chain[g]),
      .fill    (fill_w),
      .rec_out (chain[g+1])
    );
  end

  always_comb begin
    fill_w.en  = exit_rec.act && (exit_rec.mode == WALK_ADD) && !exit_rec.hit;
    fill_w.idx = exit_rec.free_found ? exit_rec.free_idx : exit_rec.old_idx;
    fill_w.ip  = exit_rec.ip;
    fill_w.mac = exit_rec.mac;
  end

  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  assign shortcut = ((((in_ip_addr ^ own_ip_r) & mask_r) != '0) ||
                     (in_ip_addr == router_ip_r)) && (router_mac_r != '0);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    own_ip_nxt     = own_ip_r;
    mask_nxt       = mask_r;
    router_ip_nxt  = router_ip_r;
    router_mac_nxt = router_mac_r;
    busy_nxt       = busy_r;
    pend_valid_nxt = pend_valid_r;
    pend_hit_nxt   = pend_hit_r;
    pend_mac_nxt   = pend_mac_r;
    pend_req_nxt   = pend_req_r;
    out_valid_nxt  = out_valid_r;
    out_hit_nxt    = out_hit_r;
    out_mac_nxt    = out_mac_r;
    out_req_nxt    = out_req_r;

    launch_nxt            = launch_r;
    launch_nxt.act        = 1'b0;
    launch_nxt.mode       = WALK_LOOKUP;
    launch_nxt.ip         = in_ip_addr;
    launch_nxt.mac        = in_mac_in;
    launch_nxt.runmax     = '0;
    launch_nxt.hit        = 1'b0;
    launch_nxt.hit_mac    = '0;
    launch_nxt.free_found = 1'b0;
    launch_nxt.free_idx   = '0;
    launch_nxt.oldest     = '0;
    launch_nxt.old_idx    = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pend_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_hit_nxt    = pend_hit_r;
      out_mac_nxt    = pend_mac_r;
      out_req_nxt    = pend_req_r;
      pend_valid_nxt = 1'b0;
      busy_nxt       = 1'b0;
    end

    if (exit_rec.act) begin
      pend_valid_nxt = 1'b1;
      pend_hit_nxt   = 1'b0;
      pend_mac_nxt   = '0;
      pend_req_nxt   = 1'b0;
      if (exit_rec.mode == WALK_LOOKUP) begin
        pend_hit_nxt = exit_rec.hit;
        pend_mac_nxt = exit_rec.hit_mac;
        pend_req_nxt = !exit_rec.hit;
      end
    end

    if (accept) begin
      busy_nxt     = 1'b1;
      pend_hit_nxt = 1'b0;
      pend_mac_nxt = '0;
      pend_req_nxt = 1'b0;
      if (in_opcode == OP_LOOKUP) begin
        if (shortcut) begin
          pend_valid_nxt = 1'b1;
          pend_hit_nxt   = 1'b1;
          pend_mac_nxt   = router_mac_r;
        end else begin
          launch_nxt.act  = 1'b1;
          launch_nxt.mode = WALK_LOOKUP;
        end
      end else if (in_ip_addr == own_ip_r) begin
        pend_valid_nxt = 1'b1;
      end else if (in_ip_addr == router_ip_r) begin
        router_mac_nxt = in_mac_in;
        pend_valid_nxt = 1'b1;
      end else if (shortcut) begin
        // Router answered; a cached copy is rewritten only when the new MAC differs from the router MAC.
        if (router_mac_r != in_mac_in) begin
          launch_nxt.act  = 1'b1;
          launch_nxt.mode = WALK_UPDATE;
        end else begin
          pend_valid_nxt = 1'b1;
        end
      end else begin
        launch_nxt.act  = 1'b1;
        launch_nxt.mode = WALK_ADD;
      end
    end

    if (cfg_we) begin
      case (cfg_index)
        REG_OWN_IP:      own_ip_nxt    = cfg_wdata;
        REG_SUBNET_MASK: mask_nxt      = cfg_wdata;
        REG_ROUTER_IP:   router_ip_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r     <= 32'hC0A8_0F16;
      mask_r       <= 32'hFFFF_FF00;
      router_ip_r  <= 32'hC0A8_0F01;
      router_mac_r <= '0;
      busy_r       <= 1'b0;
      launch_r.act <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      own_ip_r     <= own_ip_nxt;
      mask_r       <= mask_nxt;
      router_ip_r  <= router_ip_nxt;
      router_mac_r <= router_mac_nxt;
      busy_r       <= busy_nxt;
      launch_r     <= launch_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_hit_r <= pend_hit_nxt;
    pend_mac_r <= pend_mac_nxt;
    pend_req_r <= pend_req_nxt;
    out_hit_r  <= out_hit_nxt;
    out_mac_r  <= out_mac_nxt;
    out_req_r  <= out_req_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_mac_out      = out_mac_r;
  assign out_send_request = out_req_r;

endmodule
`default_nettype wire

@@ src/arpc_checker.sv @@
`default_nettype none
module arpc_checker
  import arpc_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic                 out_hit,
  input wire logic [MAC_W-1:0]     out_mac_out,
  input wire logic                 out_send_request
);

  // A result never both resolves and requests.
  a_hit_req_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_send_request))
    else $error("hit and send_request both set");

  // A result without a hit carries no MAC.
  a_miss_zero_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_mac_out == '0))
    else $error("mac_out not zero without a hit");

  // Only one item is in work: the input stalls right after a transfer.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_mac_out)))
    else $error("stalled result changed");

endmodule

bind arp_cache_lookup_and_learn_unit arpc_checker u_arpc_checker (.*);
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
module tb;
  import arpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             op;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } arp_req_t;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac;
    logic             req;
  } arp_answer_t;

  localparam int POOL_N = 12;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_opcode  = OP_LOOKUP;
  logic [IP_W-1:0]      in_ip_addr = '0;
  logic [MAC_W-1:0]     in_mac_in  = '0;
  logic                 out_stall  = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;
  wire logic            in_stall;
  wire logic            out_valid;
  wire logic            out_hit;
  wire logic [MAC_W-1:0] out_mac_out;
  wire logic            out_send_request;

  // Shadow copy of the cache and its configuration.
  logic [IP_W-1:0]  own_m, mask_m, router_m;
  logic             ent_valid [ENTRIES];
  logic [AGE_W-1:0] ent_age   [ENTRIES];
  logic [IP_W-1:0]  ent_ip    [ENTRIES];
  logic [MAC_W-1:0] ent_mac   [ENTRIES];
  logic [MAC_W-1:0] rtr_mac;

  arp_req_t    pending_requests[$];
  arp_answer_t pending_answers[$];
  logic [IP_W-1:0]  pool_ip  [POOL_N];
  logic [MAC_W-1:0] pool_mac [POOL_N];

  int  n_sent = 0;
  int  errors = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  wire quiet = (n_sent >= 600) && (n_sent < 800);

  arp_cache_lookup_and_learn_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_ip_addr      (in_ip_addr),
    .in_mac_in       (in_mac_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_mac_out     (out_mac_out),
    .out_send_request(out_send_request),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    return (a >= AGE_MAX_V) ? AGE_MAX_V : a + 1'b1;
  endfunction

  // Walks the cache the way the block does, ageing every entry passed.
  function automatic logic resolve_ip(input logic [IP_W-1:0] ip,
                                      output logic [MAC_W-1:0] mac);
    logic [AGE_W-1:0] runmax;
    runmax = '0;
    if (((((ip ^ own_m) & mask_m) != '0) || ip == router_m) && rtr_mac != '0) begin
      mac = rtr_mac;
      return 1'b1;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (!ent_valid[i]) continue;
      if (ent_ip[i] == ip) begin
        ent_age[i] = '0;
        mac = ent_mac[i];
        return 1'b1;
      end else if (ent_age[i] > runmax) begin
        runmax = ent_age[i];
        ent_age[i] = age_inc(ent_age[i]);
        if (runmax >= AGE_LIM_V) ent_valid[i] = 1'b0;
      end else begin
        ent_age[i] = age_inc(ent_age[i]);
      end
    end
    mac = '0;
    return 1'b0;
  endfunction

  function automatic int pick_victim();
    logic [AGE_W-1:0] oldest;
    int pick;
    oldest = '0;
    pick = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!ent_valid[i]) return i;
      if (ent_age[i] > oldest) begin
        oldest = ent_age[i];
        pick = i;
      end
    end
    return pick;
  endfunction

  function automatic void learn_mapping(input logic [IP_W-1:0] ip,
                                        input logic [MAC_W-1:0] mac);
    logic [MAC_W-1:0] found;
    int v;
    if (ip == own_m) return;
    if (ip == router_m) begin
      rtr_mac = mac;
      return;
    end
    if (resolve_ip(ip, found)) begin
      if (found != mac) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (ent_valid[i] && ent_ip[i] == ip) begin
            ent_age[i] = '0;
            ent_mac[i] = mac;
            break;
          end
        end
      end
    end else begin
      v = pick_victim();
      ent_age[v] = '0;
      ent_ip[v] = ip;
      ent_mac[v] = mac;
      ent_valid[v] = 1'b1;
    end
  endfunction

  function automatic void predict_answer(input logic op, input logic [IP_W-1:0] ip,
                                         input logic [MAC_W-1:0] mac);
    arp_answer_t a;
    logic [MAC_W-1:0] m;
    a = '0;
    if (op == OP_LOOKUP) begin
      if (resolve_ip(ip, m)) begin
        a.hit = 1'b1;
        a.mac = m;
      end else begin
        a.req = 1'b1;
      end
    end else begin
      learn_mapping(ip, mac);
    end
    pending_answers.push_back(a);
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= 100) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Driver: a new transfer is offered only once the previous one has gone.
  always @(posedge clk) begin : drive_requests
    arp_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_answer(in_opcode, in_ip_addr, in_mac_in);
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && (quiet || $urandom_range(0, 99) >= 23)) begin
          nxt = pending_requests.pop_front();
          in_valid   <= 1'b1;
          in_opcode  <= nxt.op;
          in_ip_addr <= nxt.ip;
          in_mac_in  <= nxt.mac;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure, with one long hold so that the block fills up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_sent >= 150) begin
      hold_done <= 1'b1;
      hold_left <= 200;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 23);
    end
  end

  always @(posedge clk) begin : check_answers
    arp_answer_t exp_a;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        exp_a = pending_answers.pop_front();
        if (out_hit !== exp_a.hit)
          report($sformatf("hit %b, expected %b", out_hit, exp_a.hit));
        if (out_mac_out !== exp_a.mac)
          report($sformatf("mac_out %h, expected %h", out_mac_out, exp_a.mac));
        if (out_send_request !== exp_a.req)
          report($sformatf("send_request %b, expected %b", out_send_request, exp_a.req));
      end
    end
  end

  task automatic push_req(input logic op, input logic [IP_W-1:0] ip,
                          input logic [MAC_W-1:0] mac);
    pending_requests.push_back('{op: op, ip: ip, mac: mac});
  endtask

  function automatic logic [MAC_W-1:0] rand_mac();
    return MAC_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [IP_W-1:0] local_ip();
    return (own_m & mask_m) | ($urandom() & ~mask_m);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_OWN_IP:      own_m = val;
      REG_SUBNET_MASK: mask_m = val;
      REG_ROUTER_IP:   router_m = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || pending_answers.size() != 0);
  endtask

  // Mostly lookups and learns over a small set of addresses so that hits,
  // updates and evictions are common; the rest is scattered noise.
  task automatic run_phase(input int n_items);
    int r, k;
    for (int i = 0; i < POOL_N; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60)      pool_ip[i] = local_ip();
      else if (r < 85) pool_ip[i] = $urandom();
      else if (r < 93) pool_ip[i] = router_m;
      else             pool_ip[i] = own_m;
      pool_mac[i] = rand_mac();
    end
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, POOL_N - 1);
      if (r < 40) begin
        push_req(OP_LOOKUP, pool_ip[k], rand_mac());
      end else if (r < 70) begin
        if ($urandom_range(0, 1) == 0) pool_mac[k] = rand_mac();
        push_req(OP_ADD, pool_ip[k], pool_mac[k]);
      end else if (r < 76) begin
        push_req(OP_ADD, router_m, ($urandom_range(0, 3) == 0) ? '0 : rand_mac());
      end else if (r < 80) begin
        push_req(OP_ADD, own_m, rand_mac());
      end else if (r < 90) begin
        push_req(OP_LOOKUP, $urandom(), rand_mac());
      end else begin
        push_req(OP_ADD, $urandom(), rand_mac());
      end
    end
  endtask

  task automatic set_config(input logic [IP_W-1:0] own, input logic [IP_W-1:0] mask,
                            input logic [IP_W-1:0] router);
    repeat (ENTRIES + 4) @(posedge clk);
    write_reg(REG_OWN_IP, own);
    write_reg(REG_SUBNET_MASK, mask);
    write_reg(REG_ROUTER_IP, router);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [IP_W-1:0] own_val;
    logic [MAC_W-1:0] upd_mac;
    own_m    = 32'hC0A8_0F16;
    mask_m   = 32'hFFFF_FF00;
    router_m = 32'hC0A8_0F01;
    rtr_mac  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_age[i]   = '0;
      ent_ip[i]    = '0;
      ent_mac[i]   = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset configuration.
    push_req(OP_LOOKUP, 32'hC0A8_0F05, '0);           // miss on an empty cache
    push_req(OP_LOOKUP, 32'h0000_0000, '0);           // off subnet, router unknown
    push_req(OP_ADD, 32'hC0A8_0F01, 48'hFFFF_FFFF_FFFF);
    push_req(OP_LOOKUP, 32'h0000_0000, '0);
    push_req(OP_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    push_req(OP_LOOKUP, 32'hC0A8_0F01, '0);           // the router itself
    push_req(OP_ADD, 32'hC0A8_0F16, 48'h0000_0000_0123); // own address is ignored
    push_req(OP_LOOKUP, 32'hC0A8_0F16, '0);
    push_req(OP_ADD, 32'h0808_0808, 48'h0000_0000_00AA); // router answers, nothing stored
    for (int i = 0; i < 9; i++)
      push_req(OP_ADD, 32'hC0A8_0F20 + i,
               (i == 0) ? '0 : (i == 8) ? 48'hFFFF_FFFF_FFFF : rand_mac());
    push_req(OP_LOOKUP, 32'hC0A8_0F21, '0);
    upd_mac = rand_mac();
    push_req(OP_ADD, 32'hC0A8_0F22, upd_mac);         // changed MAC
    push_req(OP_ADD, 32'hC0A8_0F22, upd_mac);         // same MAC again
    push_req(OP_ADD, 32'hC0A8_0F01, '0);              // router MAC forgotten
    push_req(OP_LOOKUP, 32'h0808_0808, '0);
    push_req(OP_LOOKUP, 32'hC0A8_0F28, '0);
    push_req(OP_ADD, 32'hC0A8_0FFF, 48'h5555_5555_5555);
    run_phase(240);
    wait_drained();

    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    run_phase(220);
    wait_drained();

    set_config(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    run_phase(220);
    wait_drained();

    own_val = $urandom();
    set_config(own_val, 32'hFFFF_0000, (own_val & 32'hFFFF_0000) | 32'h1);
    run_phase(220);
    wait_drained();

    set_config(32'h0A00_0005, 32'hFFFF_FFF0, 32'h0A00_0001);
    run_phase(220);
    wait_drained();

    repeat (ENTRIES + 4) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
src/arpc_pkg.sv
src/arpc_cell.sv
src/arp_cache_lookup_and_learn_unit.sv
src/arpc_checker.sv
dv/tb.sv
